[rtl/conv1d_valid_multichannel_assert.svh]
// Assertion macros for the 1-D convolution block
`ifndef CONV1D_VALID_MULTICHANNEL_ASSERT_SVH
`define CONV1D_VALID_MULTICHANNEL_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define C1D_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define C1D_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/c1d_pkg.sv]
// Shared constants, types and helpers of the 1-D convolution block
package c1d_pkg;

    localparam int MAX_TAPS   = 8;
    localparam int MAX_IN_CH  = 8;
    localparam int MAX_OUT_CH = 16;
    localparam int FRAC_BITS  = 8;

    localparam int TAP_W   = 3;
    localparam int CH_W    = 3;
    localparam int FILT_W  = 4;
    localparam int SAMP_W  = 16;
    localparam int PROD_W  = 32;
    localparam int ACC_W   = 40;
    localparam int OUT_W   = 32;
    localparam int WADDR_W = 10;
    localparam int SADDR_W = TAP_W + CH_W;

    localparam int WEIGHT_DEPTH = 1024;
    localparam int SAMPLE_DEPTH = MAX_TAPS * MAX_IN_CH;

    localparam logic [1:0] FUNC_WEIGHT = 2'd0;
    localparam logic [1:0] FUNC_BIAS   = 2'd1;
    localparam logic [1:0] FUNC_SAMPLE = 2'd2;
    localparam logic [1:0] FUNC_START  = 2'd3;

    localparam logic [1:0] REG_NUM_TAPS = 2'd0;
    localparam logic [1:0] REG_IN_CH    = 2'd1;
    localparam logic [1:0] REG_OUT_CH   = 2'd2;
    localparam logic [1:0] REG_USE_BIAS = 2'd3;

    typedef logic signed [ACC_W-1:0]  acc_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    typedef struct packed {
        logic load;
        logic shift;
        logic add;
    } cell_ctrl_t;

    function automatic logic [3:0] clamp_4(input logic [3:0] v, input logic [3:0] hi);
        logic [3:0] r;
        begin
            r = v;
            if (v == 4'd0)
            begin
                r = 4'd1;
            end
            else if (v > hi)
            begin
                r = hi;
            end
            return r;
        end
    endfunction

    function automatic logic [4:0] clamp_5(input logic [4:0] v, input logic [4:0] hi);
        logic [4:0] r;
        begin
            r = v;
            if (v == 5'd0)
            begin
                r = 5'd1;
            end
            else if (v > hi)
            begin
                r = hi;
            end
            return r;
        end
    endfunction

endpackage

[rtl/c1d_ram.sv]
// Generic simple dual-port RAM with registered read
module c1d_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/c1d_cell.sv]
// One accumulator cell of the rotating filter ring
module c1d_cell (
    input  logic                clk,
    input  c1d_pkg::cell_ctrl_t ctrl,
    input  c1d_pkg::acc_t       init_val,
    input  c1d_pkg::acc_t       nb_val,
    input  c1d_pkg::prod_t      prod,
    output c1d_pkg::acc_t       acc
);
    import c1d_pkg::*;

    acc_t acc_reg;
    acc_t acc_next;

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.load)
        begin
            acc_next = init_val;
        end
        else if (ctrl.shift)
        begin
            acc_next = nb_val + (ctrl.add ? acc_t'(prod) : acc_t'(0));
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

[rtl/conv1d_valid_multichannel.sv]
// Top level of the streaming multichannel 1-D convolution block
//
// Input stream: tuser carries the item kind (write weight, write bias, sample,
// start sequence); tdata carries table index and Q8.8 value. A sample that
// completes a time step with a full window starts a pass over the filter ring:
// one multiply-accumulate per cycle, followed by the RAM read register, the
// product register and a drain state, after which Cout results leave on the
// output stream, one per cycle while tready is high; tlast marks the last
// filter of the step. The single MAC and weight RAM port serialize the pass:
// every (tap, channel) pair walks all 16 ring cells.
// The input is not ready while a step is being computed or emitted; a stalled
// receiver holds the block in its output phase with data stable. Reset clears
// window head, channel count, fill count and registers (K=3, Cin=1, Cout=1, no
// bias). Weight, bias and window stores keep no reset value and must be written
// before use. Configuration must be written while idle; the block does not enforce it.
module conv1d_valid_multichannel (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // table_index[9:0], value[25:10], zero pad
    input  logic [1:0]  s_axis_tuser,   // func[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // filter_index[3:0], out_value[35:4], zero pad
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [4:0]  cfg_data
);
    import c1d_pkg::*;

    `include "conv1d_valid_multichannel_assert.svh"

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_COMPUTE = 2'd1;
    localparam logic [1:0] ST_DRAIN   = 2'd2;
    localparam logic [1:0] ST_EMIT    = 2'd3;

    logic [1:0] state_reg, state_next;

    logic [3:0] num_taps_reg;
    logic [3:0] in_ch_reg;
    logic [4:0] out_ch_reg;
    logic       use_bias_reg;

    logic [TAP_W-1:0] head_reg;
    logic [CH_W-1:0]  chan_reg;
    logic [3:0]       filled_reg;

    logic [TAP_W-1:0]  kc_reg;
    logic [CH_W-1:0]   ec_reg;
    logic [FILT_W-1:0] fc_reg;
    logic [FILT_W-1:0] oc_reg;
    logic              rd_valid_reg;
    logic              prod_valid_reg;
    prod_t             prod_reg;

    logic signed [SAMP_W-1:0] bias_reg [MAX_OUT_CH];

    logic [3:0] taps;
    logic [3:0] cin;
    logic [4:0] cout;

    logic [WADDR_W-1:0] table_index;
    logic [SAMP_W-1:0]  value;
    logic [1:0]         func;
    logic               in_xfer;
    logic               out_xfer;
    logic               step_done;
    logic [3:0]         filled_inc;
    logic               start_pass;
    logic               last_issue;
    logic               issuing;

    logic [SAMP_W-1:0]  w_rdata;
    logic [SAMP_W-1:0]  x_rdata;
    logic [WADDR_W-1:0] w_raddr;
    logic [SADDR_W-1:0] x_raddr;
    logic [SADDR_W-1:0] x_waddr;
    logic [TAP_W-1:0]   slot;

    acc_t acc [MAX_OUT_CH];
    logic [OUT_W-1:0] out_value;

    assign taps = clamp_4(num_taps_reg, 4'(MAX_TAPS));
    assign cin  = clamp_4(in_ch_reg, 4'(MAX_IN_CH));
    assign cout = clamp_5(out_ch_reg, 5'(MAX_OUT_CH));

    assign func        = s_axis_tuser;
    assign table_index = s_axis_tdata[9:0];
    assign value       = s_axis_tdata[25:10];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_xfer      = m_axis_tvalid && m_axis_tready;

    assign step_done  = ({1'b0, chan_reg} + 4'd1) >= cin;
    assign filled_inc = (filled_reg < 4'(MAX_TAPS)) ? filled_reg + 4'd1 : filled_reg;
    assign start_pass = in_xfer && (func == FUNC_SAMPLE) && step_done && (filled_inc >= taps);

    assign issuing    = (state_reg == ST_COMPUTE);
    assign last_issue = (fc_reg == FILT_W'(MAX_OUT_CH - 1))
                        && ({1'b0, ec_reg} == cin - 4'd1)
                        && ({1'b0, kc_reg} == taps - 4'd1);

    // Head already points past the newest step during a pass
    assign slot    = head_reg + kc_reg - taps[TAP_W-1:0];
    assign x_raddr = {slot, ec_reg};
    assign w_raddr = {kc_reg, ec_reg, fc_reg};
    assign x_waddr = {head_reg, chan_reg};

    c1d_ram #(.WIDTH(SAMP_W), .DEPTH(WEIGHT_DEPTH)) u_weight_ram (
        .clk   (clk),
        .we    (in_xfer && (func == FUNC_WEIGHT)),
        .waddr (table_index),
        .wdata (value),
        .raddr (w_raddr),
        .rdata (w_rdata)
    );

    c1d_ram #(.WIDTH(SAMP_W), .DEPTH(SAMPLE_DEPTH)) u_sample_ram (
        .clk   (clk),
        .we    (in_xfer && (func == FUNC_SAMPLE)),
        .waddr (x_waddr),
        .wdata (value),
        .raddr (x_raddr),
        .rdata (x_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_taps_reg <= 4'd3;
            in_ch_reg    <= 4'd1;
            out_ch_reg   <= 5'd1;
            use_bias_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_NUM_TAPS: num_taps_reg <= cfg_data[3:0];
                REG_IN_CH:    in_ch_reg    <= cfg_data[3:0];
                REG_OUT_CH:   out_ch_reg   <= cfg_data;
                REG_USE_BIAS: use_bias_reg <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer && (func == FUNC_BIAS) && (table_index < WADDR_W'(MAX_OUT_CH)))
        begin
            bias_reg[table_index[FILT_W-1:0]] <= value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            chan_reg   <= '0;
            filled_reg <= '0;
        end
        else if (in_xfer && (func == FUNC_START))
        begin
            head_reg   <= '0;
            chan_reg   <= '0;
            filled_reg <= '0;
        end
        else if (in_xfer && (func == FUNC_SAMPLE))
        begin
            if (step_done)
            begin
                chan_reg   <= '0;
                head_reg   <= head_reg + TAP_W'(1);
                filled_reg <= filled_inc;
            end
            else
            begin
                chan_reg <= chan_reg + CH_W'(1);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (start_pass) state_next = ST_COMPUTE;
            ST_COMPUTE: if (last_issue) state_next = ST_DRAIN;
            ST_DRAIN:   if (!rd_valid_reg && !prod_valid_reg) state_next = ST_EMIT;
            ST_EMIT:    if (out_xfer && ({1'b0, oc_reg} == cout - 5'd1)) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            kc_reg         <= '0;
            ec_reg         <= '0;
            fc_reg         <= '0;
            oc_reg         <= '0;
            rd_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rd_valid_reg   <= issuing;
            prod_valid_reg <= rd_valid_reg;
            if (start_pass)
            begin
                kc_reg <= '0;
                ec_reg <= '0;
                fc_reg <= '0;
                oc_reg <= '0;
            end
            else if (issuing)
            begin
                // Filter fastest, then channel, then tap
                fc_reg <= fc_reg + FILT_W'(1);
                if (fc_reg == FILT_W'(MAX_OUT_CH - 1))
                begin
                    if ({1'b0, ec_reg} == cin - 4'd1)
                    begin
                        ec_reg <= '0;
                        kc_reg <= kc_reg + TAP_W'(1);
                    end
                    else
                    begin
                        ec_reg <= ec_reg + CH_W'(1);
                    end
                end
            end
            else if (out_xfer)
            begin
                oc_reg <= oc_reg + FILT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= $signed(w_rdata) * $signed(x_rdata);
    end

    // Ring: each product enters at the tail as the head value moves around
    for (genvar i = 0; i < MAX_OUT_CH; i++)
    begin : g_ring
        cell_ctrl_t ctrl;
        acc_t       init_val;
        acc_t       nb_val;

        assign ctrl.load  = start_pass;
        assign ctrl.shift = prod_valid_reg || out_xfer;
        assign ctrl.add   = prod_valid_reg && (i == MAX_OUT_CH - 1);
        assign init_val   = use_bias_reg
                            ? (acc_t'(bias_reg[i]) <<< FRAC_BITS) : acc_t'(0);
        assign nb_val     = acc[(i + 1) % MAX_OUT_CH];

        c1d_cell u_cell (
            .clk      (clk),
            .ctrl     (ctrl),
            .init_val (init_val),
            .nb_val   (nb_val),
            .prod     (prod_reg),
            .acc      (acc[i])
        );
    end

    // Accumulator range stays within 32 bits after the floor shift
    assign out_value     = acc[0][ACC_W-1:FRAC_BITS];
    assign m_axis_tvalid = (state_reg == ST_EMIT);
    assign m_axis_tdata  = {4'd0, out_value, oc_reg};
    assign m_axis_tlast  = ({1'b0, oc_reg} == cout - 5'd1);

    `C1D_ASSERT_NOW(a_idle_no_out, s_axis_tready, !m_axis_tvalid,
        "output valid while input side is open")
    `C1D_ASSERT_NOW(a_prod_in_pass, prod_valid_reg,
        (state_reg == ST_COMPUTE) || (state_reg == ST_DRAIN),
        "product arrived outside a compute pass")
    `C1D_ASSERT_NEXT(a_last_reopens, out_xfer && m_axis_tlast, s_axis_tready,
        "input not reopened after last result")

endmodule
